[rtl/ppra_pkg.sv]
// shared types, codes and constants for the packet pool ring allocator
package ppra_pkg;

    // fixed field widths
    localparam int OWNER_W   = 3;   // owner index
    localparam int COUNT_W   = 5;   // hold counts, hold limits, list count
    localparam int OWN_W     = 4;   // stored slot owner, zero means unowned
    localparam int CFG_IDX_W = 3;   // register index on the config port
    localparam int CMD_W     = 2;

    localparam int NUM_LIMITS     = 8;
    localparam int MAX_RESULTS    = 16;
    localparam int DEF_POOL_SLOTS = 16;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(4);

    // contents of a store entry that was never written
    localparam int INIT_ZERO = 0;
    localparam int INIT_INC  = 1;
    localparam int INIT_DEC  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_LIST    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [COUNT_W-1:0]   a;
        logic [COUNT_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   res;
        logic                 borrow;
        logic                 zero;
    } alu_rsp_t;

endpackage

[rtl/packet_pool_ring_allocator.sv]
// top level: packet slot pool kept as a circular doubly linked ring
//   requests come in on s_axis_*: tuser carries the command (allocate, release,
//   list), tdata carries owner_id, slot_id and max_count; results leave on m_axis_*:
//   tdata carries the slot, tuser granted and empty_res, tlast marks the final
//   result of a request
//   hold limits per owner are written through cfg_we / cfg_index / cfg_wdata; the
//   user must write them only while no request is in flight, the block does not check
// sequencing, from the accepted request to the first result
//   one request at a time; s_axis_tready is high only while the block is idle
//   allocate: ALLOC_CHK, plus ALLOC_UPD when granted; release: REL_CHK alone for an
//   unowned slot, REL_CHK and REL_CNT when queue start advances, and REL_RDFP,
//   REL_SPL1 and REL_SPL2 after them when the slot is spliced in front of the free
//   pointer; list: LIST_CHK alone for the empty answer, then LIST_RDN, LIST_RDO and
//   LIST_EMIT for each listed slot; the block is idle again once the final result
//   leaves. each ring store (next, prev, owner) has one registered read port, and
//   one add/compare unit is shared; an unused command is dropped in the cycle it is
//   taken; a list of zero slots on a non-empty pool goes back to idle with no result
// reset: aresetn is synchronous, active low; the ring comes up linked in index
//   order, every slot unowned, all hold counts zero, limits at 4; no clearing pass
// backpressure: a result stays in the output register until m_axis_tready; the
//   walk of a list pauses until each result is taken
module packet_pool_ring_allocator #(
    parameter int POOL_SLOTS = ppra_pkg::DEF_POOL_SLOTS,
    localparam int SLOT_W = $clog2(POOL_SLOTS),
    localparam int S_DW = ((ppra_pkg::OWNER_W + SLOT_W + ppra_pkg::COUNT_W + 7) / 8) * 8,
    localparam int M_DW = ((SLOT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [S_DW-1:0]                 s_axis_tdata,  // owner_id, slot_id, max_count
    input  logic [ppra_pkg::CMD_W-1:0]      s_axis_tuser,  // cmd

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [M_DW-1:0]                 m_axis_tdata,  // slot
    output logic [1:0]                      m_axis_tuser,  // granted, empty_res
    output logic                            m_axis_tlast,

    input  logic                            cfg_we,
    input  logic [ppra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppra_pkg::COUNT_W-1:0]    cfg_wdata
);

    localparam int OW = ppra_pkg::OWNER_W;
    localparam int CW = ppra_pkg::COUNT_W;
    localparam int NW = ppra_pkg::OWN_W;
    // list length cap
    localparam int LIST_CAP = (POOL_SLOTS < ppra_pkg::MAX_RESULTS) ? POOL_SLOTS
                                                                   : ppra_pkg::MAX_RESULTS;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_ALLOC_CHK = 13'b0000000000010,
        ST_ALLOC_UPD = 13'b0000000000100,
        ST_REL_CHK   = 13'b0000000001000,
        ST_REL_CNT   = 13'b0000000010000,
        ST_REL_RDFP  = 13'b0000000100000,
        ST_REL_SPL1  = 13'b0000001000000,
        ST_REL_SPL2  = 13'b0000010000000,
        ST_LIST_CHK  = 13'b0000100000000,
        ST_LIST_RDN  = 13'b0001000000000,
        ST_LIST_RDO  = 13'b0010000000000,
        ST_LIST_EMIT = 13'b0100000000000,
        ST_OUT       = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] qh_reg, qh_next;      // queue start
    logic [SLOT_W-1:0] fh_reg, fh_next;      // first free
    logic [OW-1:0]     own_reg, own_next;
    logic [SLOT_W-1:0] sid_reg, sid_next;
    logic [SLOT_W-1:0] nb_reg, nb_next;      // neighbor after released slot
    logic [SLOT_W-1:0] pb_reg, pb_next;      // neighbor before released slot
    logic [SLOT_W-1:0] cur_reg, cur_next;    // list walk position
    logic [SLOT_W-1:0] nxt_reg, nxt_next;
    logic [CW-1:0]     rem_reg, rem_next;    // slots left to list
    logic              more_reg, more_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_gr_reg, out_gr_next;
    logic              out_em_reg, out_em_next;
    logic              out_last_reg, out_last_next;

    logic [CW-1:0]     hold_count_reg [ppra_pkg::NUM_LIMITS];
    logic [CW-1:0]     hold_limit_reg [ppra_pkg::NUM_LIMITS];
    logic              hold_we;

    // ring store ports
    logic              nx_we, pv_we, ow_we;
    logic [SLOT_W-1:0] nx_waddr, pv_waddr, ow_waddr;
    logic [SLOT_W-1:0] nx_wdata, pv_wdata;
    logic [NW-1:0]     ow_wdata;
    logic [SLOT_W-1:0] nx_raddr, pv_raddr, ow_raddr;
    logic [SLOT_W-1:0] nx_rdata, pv_rdata;
    logic [NW-1:0]     ow_rdata;

    ppra_pkg::alu_req_t alu_req;
    ppra_pkg::alu_rsp_t alu_rsp;

    // request fields
    ppra_pkg::cmd_t    in_cmd;
    logic [OW-1:0]     in_own;
    logic [SLOT_W-1:0] in_sid;
    logic [CW-1:0]     in_max;
    logic [CW-1:0]     in_iters;
    logic              in_sid_bad;
    logic              s_accept;
    logic [CW-1:0]     cnt;
    logic [CW-1:0]     lim;
    logic              list_stop;

    assign in_cmd     = ppra_pkg::cmd_t'(s_axis_tuser);
    assign in_own     = s_axis_tdata[OW-1:0];
    assign in_sid     = s_axis_tdata[OW +: SLOT_W];
    assign in_max     = s_axis_tdata[OW + SLOT_W +: CW];
    assign in_iters   = (in_max > CW'(LIST_CAP)) ? CW'(LIST_CAP) : in_max;
    assign in_sid_bad = ({1'b0, in_sid} >= (SLOT_W + 1)'(POOL_SLOTS));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign cnt = hold_count_reg[own_reg];
    assign lim = hold_limit_reg[own_reg];

    ppra_store #(
        .WIDTH     (SLOT_W),
        .DEPTH     (POOL_SLOTS),
        .INIT_KIND (ppra_pkg::INIT_INC)
    ) u_next (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (nx_we),
        .waddr   (nx_waddr),
        .wdata   (nx_wdata),
        .raddr   (nx_raddr),
        .rdata   (nx_rdata)
    );

    ppra_store #(
        .WIDTH     (SLOT_W),
        .DEPTH     (POOL_SLOTS),
        .INIT_KIND (ppra_pkg::INIT_DEC)
    ) u_prev (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (pv_we),
        .waddr   (pv_waddr),
        .wdata   (pv_wdata),
        .raddr   (pv_raddr),
        .rdata   (pv_rdata)
    );

    ppra_store #(
        .WIDTH     (NW),
        .DEPTH     (POOL_SLOTS),
        .INIT_KIND (ppra_pkg::INIT_ZERO)
    ) u_owner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ow_we),
        .waddr   (ow_waddr),
        .wdata   (ow_wdata),
        .raddr   (ow_raddr),
        .rdata   (ow_rdata)
    );

    ppra_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        qh_next       = qh_reg;
        fh_next       = fh_reg;
        own_next      = own_reg;
        sid_next      = sid_reg;
        nb_next       = nb_reg;
        pb_next       = pb_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        rem_next      = rem_reg;
        more_next     = more_reg;
        out_slot_next = out_slot_reg;
        out_gr_next   = out_gr_reg;
        out_em_next   = out_em_reg;
        out_last_next = out_last_reg;
        hold_we       = 1'b0;
        nx_we         = 1'b0;
        nx_waddr      = sid_reg;
        nx_wdata      = fh_reg;
        pv_we         = 1'b0;
        pv_waddr      = fh_reg;
        pv_wdata      = sid_reg;
        ow_we         = 1'b0;
        ow_waddr      = sid_reg;
        ow_wdata      = '0;
        nx_raddr      = cur_reg;
        pv_raddr      = fh_reg;
        ow_raddr      = fh_reg;
        alu_req.op    = ppra_pkg::ALU_SUB;
        alu_req.a     = cnt;
        alu_req.b     = lim;
        list_stop     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // look up the slot the request is about
                nx_raddr = in_sid;
                pv_raddr = in_sid;
                case (in_cmd)
                    ppra_pkg::CMD_RELEASE: ow_raddr = in_sid;
                    ppra_pkg::CMD_LIST:    ow_raddr = qh_reg;
                    default:               ow_raddr = fh_reg;
                endcase
                if (s_accept) begin
                    own_next      = in_own;
                    sid_next      = in_sid;
                    cur_next      = qh_reg;
                    rem_next      = in_iters;
                    more_next     = 1'b0;
                    out_gr_next   = 1'b0;
                    out_em_next   = 1'b0;
                    out_last_next = 1'b1;
                    case (in_cmd)
                        ppra_pkg::CMD_ALLOC: begin
                            state_next = ST_ALLOC_CHK;
                        end
                        ppra_pkg::CMD_RELEASE: begin
                            if (in_sid_bad) begin
                                out_slot_next = in_sid;
                                state_next    = ST_OUT;
                            end else begin
                                state_next = ST_REL_CHK;
                            end
                        end
                        ppra_pkg::CMD_LIST: begin
                            state_next = ST_LIST_CHK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ALLOC_CHK: begin
                // count below limit and first-free slot unowned
                nx_raddr = fh_reg;
                if ((ow_rdata == '0) && alu_rsp.borrow) begin
                    ow_we      = 1'b1;
                    ow_waddr   = fh_reg;
                    ow_wdata   = NW'({1'b0, own_reg}) + NW'(1);
                    state_next = ST_ALLOC_UPD;
                end else begin
                    out_slot_next = '0;
                    state_next    = ST_OUT;
                end
            end

            ST_ALLOC_UPD: begin
                alu_req.op    = ppra_pkg::ALU_ADD;
                alu_req.b     = CW'(1);
                hold_we       = 1'b1;
                fh_next       = nx_rdata;
                out_slot_next = fh_reg;
                out_gr_next   = 1'b1;
                state_next    = ST_OUT;
            end

            ST_REL_CHK: begin
                if (ow_rdata == '0) begin
                    out_slot_next = sid_reg;
                    state_next    = ST_OUT;
                end else begin
                    own_next   = OW'(ow_rdata - NW'(1));
                    ow_we      = 1'b1;
                    ow_waddr   = sid_reg;
                    ow_wdata   = '0;
                    nb_next    = nx_rdata;
                    pb_next    = pv_rdata;
                    state_next = ST_REL_CNT;
                end
            end

            ST_REL_CNT: begin
                // saturating decrement of the owner's count
                alu_req.b = CW'(1);
                hold_we   = !alu_rsp.borrow;
                if (qh_reg == sid_reg) begin
                    qh_next       = nb_reg;
                    out_slot_next = sid_reg;
                    out_gr_next   = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    // unlink
                    nx_we      = 1'b1;
                    nx_waddr   = pb_reg;
                    nx_wdata   = nb_reg;
                    pv_we      = 1'b1;
                    pv_waddr   = nb_reg;
                    pv_wdata   = pb_reg;
                    state_next = ST_REL_RDFP;
                end
            end

            ST_REL_RDFP: begin
                pv_raddr   = fh_reg;
                state_next = ST_REL_SPL1;
            end

            ST_REL_SPL1: begin
                nx_we      = 1'b1;
                nx_waddr   = pv_rdata;
                nx_wdata   = sid_reg;
                pv_we      = 1'b1;
                pv_waddr   = sid_reg;
                pv_wdata   = pv_rdata;
                state_next = ST_REL_SPL2;
            end

            ST_REL_SPL2: begin
                nx_we         = 1'b1;
                nx_waddr      = sid_reg;
                nx_wdata      = fh_reg;
                pv_we         = 1'b1;
                pv_waddr      = fh_reg;
                pv_wdata      = sid_reg;
                fh_next       = sid_reg;
                out_slot_next = sid_reg;
                out_gr_next   = 1'b1;
                state_next    = ST_OUT;
            end

            ST_LIST_CHK: begin
                if (ow_rdata == '0) begin
                    out_slot_next = '0;
                    out_em_next   = 1'b1;
                    state_next    = ST_OUT;
                end else if (rem_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_LIST_RDN;
                end
            end

            ST_LIST_RDN: begin
                nx_raddr   = cur_reg;
                state_next = ST_LIST_RDO;
            end

            ST_LIST_RDO: begin
                nxt_next   = nx_rdata;
                ow_raddr   = nx_rdata;
                state_next = ST_LIST_EMIT;
            end

            ST_LIST_EMIT: begin
                alu_req.a     = rem_reg;
                alu_req.b     = CW'(1);
                list_stop     = (ow_rdata == '0) || alu_rsp.zero;
                out_slot_next = cur_reg;
                out_gr_next   = 1'b0;
                out_em_next   = 1'b0;
                out_last_next = list_stop;
                more_next     = !list_stop;
                rem_next      = alu_rsp.res;
                cur_next      = nxt_reg;
                state_next    = ST_OUT;
            end

            ST_OUT: begin
                if (m_axis_tready) begin
                    state_next = more_reg ? ST_LIST_RDN : ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            qh_reg    <= '0;
            fh_reg    <= '0;
            more_reg  <= 1'b0;
            for (int i = 0; i < ppra_pkg::NUM_LIMITS; i++) begin
                hold_count_reg[i] <= '0;
                hold_limit_reg[i] <= ppra_pkg::LIMIT_RESET;
            end
        end else begin
            state_reg <= state_next;
            qh_reg    <= qh_next;
            fh_reg    <= fh_next;
            more_reg  <= more_next;
            if (hold_we) begin
                hold_count_reg[own_reg] <= alu_rsp.res;
            end
            if (cfg_we) begin
                hold_limit_reg[cfg_index] <= cfg_wdata;
            end
        end
        own_reg      <= own_next;
        sid_reg      <= sid_next;
        nb_reg       <= nb_next;
        pb_reg       <= pb_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        rem_reg      <= rem_next;
        out_slot_reg <= out_slot_next;
        out_gr_reg   <= out_gr_next;
        out_em_reg   <= out_em_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = M_DW'(out_slot_reg);
    assign m_axis_tuser  = {out_em_reg, out_gr_reg};
    assign m_axis_tlast  = out_last_reg;

    // one request at a time: never taking a request while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    // an empty-pool answer is never a grant and always ends the run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("empty result not final or marked granted");

    // an unused command is dropped at once
    a_none_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_cmd == ppra_pkg::CMD_NONE)) |=> s_axis_tready)
        else $error("unused command did not return to idle");

    // a taken final result returns the block to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block busy after final result");

    // a granted allocation moves the free pointer
    a_alloc_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC_UPD) |=> (fh_reg == $past(nx_rdata)))
        else $error("free pointer not advanced on grant");

endmodule

[rtl/ppra_ram.sv]
// generic single write, single read ram with registered read data
module ppra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ppra_store.sv]
// ring state store: ram plus per-entry valid bits, unwritten entries read as their reset value
module ppra_store #(
    parameter int WIDTH     = 4,
    parameter int DEPTH     = 16,
    parameter int INIT_KIND = ppra_pkg::INIT_ZERO,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [DEPTH-1:0] valid_reg;
    logic             vq_reg;
    logic [AW-1:0]    aq_reg;
    logic [WIDTH-1:0] ram_rdata;
    logic [AW-1:0]    init_val;

    ppra_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            vq_reg <= valid_reg[raddr];
        end
        aq_reg <= raddr;
    end

    // reset value as a function of the entry index
    always_comb begin
        case (INIT_KIND)
            ppra_pkg::INIT_INC: begin
                init_val = (aq_reg == AW'(DEPTH - 1)) ? '0 : aq_reg + AW'(1);
            end
            ppra_pkg::INIT_DEC: begin
                init_val = (aq_reg == '0) ? AW'(DEPTH - 1) : aq_reg - AW'(1);
            end
            default: begin
                init_val = '0;
            end
        endcase
    end

    assign rdata = vq_reg ? ram_rdata : WIDTH'(init_val);

endmodule

[rtl/ppra_alu.sv]
// shared add/subtract and compare unit for hold counts and list counting
module ppra_alu (
    input  ppra_pkg::alu_req_t req,
    output ppra_pkg::alu_rsp_t rsp
);

    logic [ppra_pkg::COUNT_W:0] wide;

    always_comb begin
        case (req.op)
            ppra_pkg::ALU_ADD: begin
                wide = {1'b0, req.a} + {1'b0, req.b};
            end
            ppra_pkg::ALU_SUB: begin
                wide = {1'b0, req.a} - {1'b0, req.b};
            end
            default: begin
                wide = '0;
            end
        endcase
        rsp.res    = wide[ppra_pkg::COUNT_W-1:0];
        rsp.borrow = wide[ppra_pkg::COUNT_W];
        rsp.zero   = (wide[ppra_pkg::COUNT_W-1:0] == '0);
    end

endmodule

[test/packet_pool_ring_allocator_tb.sv]
// self-checking testbench for the packet pool ring allocator
`timescale 1ns / 100ps

module packet_pool_ring_allocator_tb;

    localparam int POOL       = ppra_pkg::DEF_POOL_SLOTS;
    localparam int OWNERS     = ppra_pkg::NUM_LIMITS;
    localparam int SETTLE     = 20;      // cycles for a request with no result to finish
    localparam int HOLD_LEN   = 300;     // long receiver hold-off, in cycles
    localparam int OWNER_SOLO = 1;       // owner limited to a single slot in the first setting
    localparam int OWNER_SHUT = 6;       // owner locked out in the first setting

    // one result as it leaves the block
    typedef struct packed {
        logic [3:0] slot;
        logic       granted;
        logic       empty_res;
        logic       last;
    } pool_result_t;

    // one directed row; want is only used when typed is set
    typedef struct packed {
        ppra_pkg::cmd_t cmd;
        logic [2:0]     owner;
        logic [3:0]     slot;
        logic [4:0]     maxc;
        logic           typed;
        pool_result_t   want;
    } stim_row_t;

    localparam int N_ROWS = 19;

    // directed sequence, run right after reset with every limit at 4
    localparam stim_row_t SCRIPT [N_ROWS] = '{
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd16, 1'b1, '{4'd0,  1'b0, 1'b1, 1'b1}}, // empty
        '{ppra_pkg::CMD_RELEASE, 3'd0, 4'd15, 5'd0,  1'b1, '{4'd15, 1'b0, 1'b0, 1'b1}}, // unowned
        '{ppra_pkg::CMD_ALLOC,   3'd0, 4'd0,  5'd0,  1'b1, '{4'd0,  1'b1, 1'b0, 1'b1}},
        '{ppra_pkg::CMD_ALLOC,   3'd7, 4'd0,  5'd0,  1'b1, '{4'd1,  1'b1, 1'b0, 1'b1}},
        '{ppra_pkg::CMD_ALLOC,   3'd0, 4'd9,  5'd0,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_ALLOC,   3'd0, 4'd0,  5'd31, 1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_ALLOC,   3'd0, 4'd0,  5'd0,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_ALLOC,   3'd0, 4'd0,  5'd0,  1'b1, '{4'd0,  1'b0, 1'b0, 1'b1}}, // at limit
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd0,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}}, // none
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd3,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd31, 1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_NONE,    3'd5, 4'd10, 5'd9,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}}, // dropped
        '{ppra_pkg::CMD_RELEASE, 3'd0, 4'd2,  5'd0,  1'b1, '{4'd2,  1'b1, 1'b0, 1'b1}}, // spliced
        '{ppra_pkg::CMD_RELEASE, 3'd0, 4'd0,  5'd0,  1'b1, '{4'd0,  1'b1, 1'b0, 1'b1}}, // head
        '{ppra_pkg::CMD_RELEASE, 3'd0, 4'd0,  5'd0,  1'b1, '{4'd0,  1'b0, 1'b0, 1'b1}}, // twice
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd16, 1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_ALLOC,   3'd3, 4'd0,  5'd0,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_ALLOC,   3'd5, 4'd0,  5'd0,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}},
        '{ppra_pkg::CMD_LIST,    3'd0, 4'd0,  5'd1,  1'b0, '{4'd0,  1'b0, 1'b0, 1'b0}}
    };

    // dut ports, all known from time zero
    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // owner_id[2:0], slot_id[6:3], max_count[11:7]
    logic [15:0]                    s_axis_tdata  = '0;
    logic [ppra_pkg::CMD_W-1:0]     s_axis_tuser  = ppra_pkg::CMD_NONE;  // cmd
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;  // slot[3:0]
    logic [1:0]                     m_axis_tuser;  // granted, empty_res
    logic                           m_axis_tlast;
    logic                           cfg_we        = 1'b0;
    logic [ppra_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ppra_pkg::COUNT_W-1:0]   cfg_wdata     = '0;

    // shadow of the ring, owners, counts and limits
    logic [3:0]                   link_next [POOL];
    logic [3:0]                   link_prev [POOL];
    logic [3:0]                   slot_tag  [POOL];   // zero is unowned, else owner plus one
    logic [ppra_pkg::COUNT_W-1:0] held      [OWNERS];
    logic [ppra_pkg::COUNT_W-1:0] limit     [OWNERS];
    logic [3:0]                   queue_ptr;
    logic [3:0]                   free_ptr;

    pool_result_t due_results [$];   // results still owed by the block, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int n_requests    = 0;
    int n_checked     = 0;
    int n_grants      = 0;
    int n_refused     = 0;
    int n_walked      = 0;

    packet_pool_ring_allocator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // work out what one accepted request must produce, and move the shadow state on
    task automatic predict_pool(input ppra_pkg::cmd_t c, input logic [2:0] o,
                                input logic [3:0] s, input logic [4:0] mc);
        logic [3:0] f, p, n, fp, cur;
        logic [2:0] who;
        int         walk;
        bit         stop;
        case (c)
            ppra_pkg::CMD_ALLOC: begin
                f = free_ptr;
                if (slot_tag[f] == 4'd0 && held[o] < limit[o]) begin
                    slot_tag[f] = {1'b0, o} + 4'd1;
                    held[o]     = held[o] + 1'b1;
                    free_ptr    = link_next[f];
                    due_results.push_back(pool_result_t'{f, 1'b1, 1'b0, 1'b1});
                    n_grants++;
                end else begin
                    // full pool or owner at its limit
                    due_results.push_back(pool_result_t'{4'd0, 1'b0, 1'b0, 1'b1});
                    n_refused++;
                end
            end
            ppra_pkg::CMD_RELEASE: begin
                if (slot_tag[s] == 4'd0) begin
                    due_results.push_back(pool_result_t'{s, 1'b0, 1'b0, 1'b1});
                end else begin
                    who = 3'(slot_tag[s] - 4'd1);
                    if (held[who] != '0)
                        held[who] = held[who] - 1'b1;
                    slot_tag[s] = 4'd0;
                    if (queue_ptr == s) begin
                        queue_ptr = link_next[s];
                    end else begin
                        // unlink, then splice in just ahead of the free pointer
                        p = link_prev[s];
                        n = link_next[s];
                        link_next[p] = n;
                        link_prev[n] = p;
                        fp = link_prev[free_ptr];
                        link_next[fp] = s;
                        link_prev[s]  = fp;
                        link_next[s]  = free_ptr;
                        link_prev[free_ptr] = s;
                        free_ptr = s;
                    end
                    due_results.push_back(pool_result_t'{s, 1'b1, 1'b0, 1'b1});
                end
            end
            ppra_pkg::CMD_LIST: begin
                n_walked++;
                if (slot_tag[queue_ptr] == 4'd0) begin
                    due_results.push_back(pool_result_t'{4'd0, 1'b0, 1'b1, 1'b1});
                end else begin
                    walk = mc;
                    if (walk > POOL)
                        walk = POOL;
                    if (walk > ppra_pkg::MAX_RESULTS)
                        walk = ppra_pkg::MAX_RESULTS;
                    cur = queue_ptr;
                    for (int k = 0; k < walk; k++) begin
                        stop = (slot_tag[link_next[cur]] == 4'd0) || (k + 1 == walk);
                        due_results.push_back(pool_result_t'{cur, 1'b0, 1'b0, stop});
                        if (stop)
                            break;
                        cur = link_next[cur];
                    end
                end
            end
            default: ;  // unused command, nothing comes back
        endcase
    endtask

    // offer one request, hold it until taken, then book its expected results
    task automatic send_req(input ppra_pkg::cmd_t c, input logic [2:0] o,
                            input logic [3:0] s, input logic [4:0] mc, input bit typed,
                            input pool_result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, mc, s, o};
        s_axis_tuser  <= c;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        n_requests++;
        predict_pool(c, o, s, mc);
        // directed rows with a typed answer replace the single predicted one
        if (typed) begin
            void'(due_results.pop_back());
            due_results.push_back(want);
        end
    endtask

    // random request; most releases hit a slot that is really held
    task automatic send_random(input int alloc_wt, input int rel_wt);
        int             r;
        ppra_pkg::cmd_t c;
        logic [3:0]     s;
        logic [4:0]     mc;
        logic [3:0]     owned [$];
        r = $urandom_range(99);
        if (r < alloc_wt)
            c = ppra_pkg::CMD_ALLOC;
        else if (r < alloc_wt + rel_wt)
            c = ppra_pkg::CMD_RELEASE;
        else if (r < 95)
            c = ppra_pkg::CMD_LIST;
        else
            c = ppra_pkg::CMD_NONE;
        for (int i = 0; i < POOL; i++)
            if (slot_tag[i] != 4'd0)
                owned.push_back(4'(i));
        if (owned.size() != 0 && $urandom_range(99) < 80)
            s = owned[$urandom_range(owned.size() - 1)];
        else
            s = 4'($urandom_range(POOL - 1));
        r = $urandom_range(99);
        if (r < 70)
            mc = 5'($urandom_range(16));
        else if (r < 85)
            mc = 5'($urandom_range(31, 17));
        else
            mc = 5'($urandom_range(3, 1));
        send_req(c, 3'($urandom_range(OWNERS - 1)), s, mc, 1'b0, '0);
    endtask

    // stop offering and let every owed result come back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // write all eight hold limits back to back; only called while the block is idle
    task automatic load_limits(input bit first_set);
        logic [ppra_pkg::COUNT_W-1:0] v;
        for (int i = 0; i < OWNERS; i++) begin
            if (first_set)
                v = (i == OWNER_SHUT) ? 5'd0 : (i == OWNER_SOLO) ? 5'd1 : 5'd16;
            else
                v = 5'($urandom_range(16));
            cfg_we    <= 1'b1;
            cfg_index <= ppra_pkg::CFG_IDX_W'(i);
            cfg_wdata <= v;
            @(posedge aclk);
            limit[i] = v;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random ready, with one long hold-off when asked for
    always @(posedge aclk) begin
        if (hold_asked != hold_done) begin
            hold_done     <= hold_asked;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each taken result with the oldest one owed
    always @(posedge aclk) begin
        pool_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = pool_result_t'{m_axis_tdata[3:0], m_axis_tuser[0], m_axis_tuser[1],
                                 m_axis_tlast};
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none,", $time,
                         " got slot %0d granted %0b empty %0b last %0b",
                         got.slot, got.granted, got.empty_res, got.last);
            end else begin
                want = due_results.pop_front();
                n_checked++;
                if (got.slot !== want.slot || got.granted !== want.granted ||
                    got.empty_res !== want.empty_res || got.last !== want.last) begin
                    errors++;
                    $display("%0t: result mismatch, expected slot %0d granted %0b", $time,
                             want.slot, want.granted,
                             " empty %0b last %0b,", want.empty_res, want.last,
                             " got slot %0d granted %0b empty %0b last %0b",
                             got.slot, got.granted, got.empty_res, got.last);
                end
            end
        end
    end

    // overall time limit
    initial begin
        #1_000_000;
        $display("%0t: timeout with %0d results still owed", $time, due_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        // shadow comes up the way the block does after reset
        for (int i = 0; i < POOL; i++) begin
            link_next[i] = 4'((i + 1) % POOL);
            link_prev[i] = 4'((i + POOL - 1) % POOL);
            slot_tag[i]  = 4'd0;
        end
        for (int i = 0; i < OWNERS; i++) begin
            held[i]  = '0;
            limit[i] = ppra_pkg::LIMIT_RESET;
        end
        queue_ptr = 4'd0;
        free_ptr  = 4'd0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset limits, sender idling less than the receiver
        send_idle_pct = 37;
        recv_idle_pct = 77;
        for (int i = 0; i < N_ROWS; i++)
            send_req(SCRIPT[i].cmd, SCRIPT[i].owner, SCRIPT[i].slot, SCRIPT[i].maxc,
                     SCRIPT[i].typed, SCRIPT[i].want);
        drain();

        // wide limits with one owner shut out and one held to a single slot;
        // allocate-heavy so the pool runs full
        load_limits(1'b1);
        send_idle_pct = 37;
        recv_idle_pct = 77;
        repeat (55) send_random(55, 30);
        drain();

        // random limits, balanced traffic, roles of the two sides swapped
        load_limits(1'b0);
        send_idle_pct = 77;
        recv_idle_pct = 37;
        repeat (55) send_random(35, 40);
        drain();

        // random limits again, no idling; starts with a long hold-off on the result side
        // so a result sits in the output register while requests keep being offered
        load_limits(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        repeat (55) send_random(40, 35);
        drain();

        $display("covered %0d requests and %0d checked results: %0d grants, %0d refusals,",
                 n_requests, n_checked, n_grants, n_refused);
        $display("%0d list walks, three limit settings and one long result-side hold-off",
                 n_walked);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
